>>> src/stwh_pkg.sv
// ----------------------------------------------------------------------------
// stwh_pkg
// Shared types and constants of the sliding time window histogrammer.
// ----------------------------------------------------------------------------
package stwh_pkg;

    // default sizes
    localparam int DEF_WINDOW_DEPTH  = 64;
    localparam int DEF_MAX_TIME_BINS = 8;
    localparam int DEF_MAX_CHAN_BINS = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_BIN_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_BIN_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_BINS_USED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_BINS_USED = 3'd5;

    // request codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_BINS = 1'b1;

    // field widths
    localparam int TIME_W  = 64;
    localparam int CHAN_W  = 20;
    localparam int ADC_W   = 32;
    localparam int PEAK_W  = 16;
    localparam int TOT_W   = 16;
    localparam int ACC_W   = 38;
    localparam int SUM16_W = 22;
    localparam int CBW_W   = 16;
    localparam int BINS_W  = 4;

    // one stored hit
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [CHAN_W-1:0] channel;
        logic [ADC_W-1:0]  adc;
        logic [PEAK_W-1:0] peak;
        logic [TOT_W-1:0]  tot;
    } t_hit;

endpackage

>>> src/sliding_time_window_histogrammer.sv
// ----------------------------------------------------------------------------
// sliding_time_window_histogrammer
// Time-ordered hit window with running sums and a time-by-channel histogram.
// ----------------------------------------------------------------------------
// push: an empty window goes straight to append and result; else the oldest hit
//   is read and checked and evicted while too old (append once the window
//   empties) or once from a full store, then the new oldest is read; one result
// bin request: clear sweep, then per kept hit a read and a range check, and for
//   a hit in range a divide, a histogram read and write; then each bin is read and emitted
// results cannot be stalled; reset clears pointers, counts, sums, config
module sliding_time_window_histogrammer
    import stwh_pkg::*;
#(
    parameter int WINDOW_DEPTH  = DEF_WINDOW_DEPTH,
    parameter int MAX_TIME_BINS = DEF_MAX_TIME_BINS,
    parameter int MAX_CHAN_BINS = DEF_MAX_CHAN_BINS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_func,
    input  logic [TIME_W-1:0]    i_hit_start_time,
    input  logic [CHAN_W-1:0]    i_hit_channel,
    input  logic [ADC_W-1:0]     i_hit_adc_integral,
    input  logic [PEAK_W-1:0]    i_hit_adc_peak,
    input  logic [TOT_W-1:0]     i_hit_time_over_thr,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_valid,
    output logic                 o_is_bin,
    output logic [5:0]           o_bin_idx,
    output logic [ACC_W-1:0]     o_bin_value,
    output logic                 o_last,
    output logic [TIME_W-1:0]    o_window_begin,
    output logic [6:0]           o_hit_count,
    output logic [ACC_W-1:0]     o_adc_total,
    output logic [SUM16_W-1:0]   o_peak_total,
    output logic [SUM16_W-1:0]   o_tot_total,
    output logic                 o_overflow
);

    localparam int PW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int HD    = MAX_TIME_BINS * MAX_CHAN_BINS;
    localparam int HW    = (HD > 1) ? $clog2(HD) : 1;
    localparam int HCW   = $clog2(HD + 1);
    localparam int NTW   = $clog2(MAX_TIME_BINS + 1);
    localparam int NCW   = $clog2(MAX_CHAN_BINS + 1);
    localparam int MAXB  = (MAX_TIME_BINS > MAX_CHAN_BINS) ? MAX_TIME_BINS : MAX_CHAN_BINS;
    localparam int QW    = (MAXB > 1) ? $clog2(MAXB) : 1;
    localparam int KW    = (QW > 1) ? $clog2(QW) : 1;
    localparam int RW    = ADC_W + QW;
    localparam int TLW   = 32 + NTW;
    localparam int CLW   = CBW_W + NCW;
    localparam int IXW   = QW + NTW + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVC  = 4'd1;
    localparam logic [3:0] S_FULL = 4'd2;
    localparam logic [3:0] S_APP  = 4'd3;
    localparam logic [3:0] S_POUT = 4'd4;
    localparam logic [3:0] S_BCLR = 4'd5;
    localparam logic [3:0] S_BRD  = 4'd6;
    localparam logic [3:0] S_BCHK = 4'd7;
    localparam logic [3:0] S_BDIV = 4'd8;
    localparam logic [3:0] S_BHRD = 4'd9;
    localparam logic [3:0] S_BHWR = 4'd10;
    localparam logic [3:0] S_BORD = 4'd11;
    localparam logic [3:0] S_BOEM = 4'd12;

    // ring address: base plus offset, offset at most the depth
    function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(WINDOW_DEPTH)) s = s - (CW+1)'(WINDOW_DEPTH);
        return s[PW-1:0];
    endfunction

    // configuration registers
    logic [31:0]        r_wlen, r_tbw;
    logic [CBW_W-1:0]   r_cbw;
    logic [CHAN_W-1:0]  r_first;
    logic [BINS_W-1:0]  r_tbu, r_cbu;

    // control and window state
    logic [3:0]         r_state;
    logic [PW-1:0]      r_ptr;
    logic [CW-1:0]      r_cnt, r_idx;
    logic [TIME_W-1:0]  r_start;
    logic [ACC_W-1:0]   r_adc;
    logic [SUM16_W-1:0] r_pk, r_tot;
    logic               r_ovf;

    // latched request
    t_hit               r_item;
    logic [NTW-1:0]     r_nt;
    logic [TLW-1:0]     r_tlim;
    logic [CLW-1:0]     r_clim;
    logic [HCW-1:0]     r_nbins, r_bin;

    // binning datapath
    logic [RW-1:0]      r_trem, r_crem;
    logic [QW-1:0]      r_tq, r_cq;
    logic [KW-1:0]      r_k;
    logic [ADC_W-1:0]   r_hadc;
    logic [HW-1:0]      r_hidx;

    // result registers
    logic               r_valid, r_obin, r_olast;
    logic [HW-1:0]      r_oidx;
    logic [ACC_W-1:0]   r_oval;

    // memories
    t_hit               r_hit_mem [WINDOW_DEPTH];
    t_hit               r_hit_rd;
    logic [ACC_W-1:0]   r_hist_mem [HD];
    logic [ACC_W-1:0]   r_hist_rd;

    logic               hit_re, hit_we, hist_re, hist_we;
    logic [PW-1:0]      hit_raddr, hit_waddr, ptr_nx;
    t_hit               hit_wdata;
    logic [HW-1:0]      hist_addr;
    logic [ACC_W-1:0]   hist_wdata;

    logic               accept;
    logic [NTW-1:0]     nt_c;
    logic [NCW-1:0]     nc_c;
    logic [TIME_W-1:0]  ev_diff, bin_dt;
    logic [CHAN_W-1:0]  bin_cd;
    logic               bin_in;
    logic [RW-1:0]      tsh, csh;
    logic [IXW-1:0]     idx_full;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign ptr_nx      = ring_add(r_ptr, CW'(1));

    // clamped bin counts
    always_comb begin
        if (r_tbu == '0) nt_c = NTW'(1);
        else if (int'(r_tbu) > MAX_TIME_BINS) nt_c = NTW'(MAX_TIME_BINS);
        else nt_c = NTW'(r_tbu);
        if (r_cbu == '0) nc_c = NCW'(1);
        else if (int'(r_cbu) > MAX_CHAN_BINS) nc_c = NCW'(MAX_CHAN_BINS);
        else nc_c = NCW'(r_cbu);
    end

    // datapath terms
    always_comb begin
        ev_diff  = r_item.start_time - r_hit_rd.start_time;
        bin_dt   = r_hit_rd.start_time - r_start;
        bin_cd   = r_hit_rd.channel - r_first;
        bin_in   = (r_hit_rd.channel >= r_first) &&
                   (bin_dt < TIME_W'(r_tlim)) && (CLW'(bin_cd) < r_clim);
        tsh      = RW'(r_tbw) << r_k;
        csh      = RW'(r_cbw) << r_k;
        idx_full = IXW'(r_cq) * IXW'(r_nt) + IXW'(r_tq);
    end

    // memory port control
    always_comb begin
        hit_re     = 1'b0;
        hit_raddr  = r_ptr;
        hit_we     = 1'b0;
        hit_waddr  = ring_add(r_ptr, r_cnt);
        hit_wdata  = r_item;
        hist_re    = 1'b0;
        hist_we    = 1'b0;
        hist_addr  = r_bin[HW-1:0];
        hist_wdata = '0;
        case (r_state)
            S_IDLE: begin
                hit_re = accept;
            end
            S_EVC: begin
                hit_re    = 1'b1;
                hit_raddr = ptr_nx;
            end
            S_APP: begin
                hit_we = 1'b1;
                if (r_cnt == '0) hit_waddr = '0;
            end
            S_BCLR: begin
                hist_we = 1'b1;
            end
            S_BRD: begin
                hit_re    = 1'b1;
                hit_raddr = ring_add(r_ptr, r_idx);
            end
            S_BHRD: begin
                hist_re   = 1'b1;
                hist_addr = idx_full[HW-1:0];
            end
            S_BHWR: begin
                hist_we    = 1'b1;
                hist_addr  = r_hidx;
                hist_wdata = r_hist_rd + ACC_W'(r_hadc);
            end
            S_BORD: begin
                hist_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // hit store
    always_ff @(posedge i_clk) begin
        if (hit_we) r_hit_mem[hit_waddr] <= hit_wdata;
        if (hit_re) r_hit_rd <= r_hit_mem[hit_raddr];
    end

    // histogram store
    always_ff @(posedge i_clk) begin
        if (hist_we) r_hist_mem[hist_addr] <= hist_wdata;
        if (hist_re) r_hist_rd <= r_hist_mem[hist_addr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= 32'd1000;
            r_tbw   <= 32'd100;
            r_cbw   <= 16'd1;
            r_first <= '0;
            r_tbu   <= 4'd8;
            r_cbu   <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WINDOW_LENGTH:  r_wlen  <= i_cfg_data;
                REG_TIME_BIN_WIDTH: r_tbw   <= i_cfg_data;
                REG_CHAN_BIN_WIDTH: r_cbw   <= i_cfg_data[CBW_W-1:0];
                REG_FIRST_CHAN:     r_first <= i_cfg_data[CHAN_W-1:0];
                REG_TIME_BINS_USED: r_tbu   <= i_cfg_data[BINS_W-1:0];
                REG_CHAN_BINS_USED: r_cbu   <= i_cfg_data[BINS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // request payload and bin limits
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.start_time <= i_hit_start_time;
            r_item.channel    <= i_hit_channel;
            r_item.adc        <= i_hit_adc_integral;
            r_item.peak       <= i_hit_adc_peak;
            r_item.tot        <= i_hit_time_over_thr;
            r_nt    <= nt_c;
            r_tlim  <= TLW'(nt_c) * TLW'(r_tbw);
            r_clim  <= CLW'(nc_c) * CLW'(r_cbw);
            r_nbins <= HCW'(nt_c) * HCW'(nc_c);
        end
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_start <= '0;
            r_adc   <= '0;
            r_pk    <= '0;
            r_tot   <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_bin   <= '0;
            r_k     <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ovf <= 1'b0;
                        if (i_func == FUNC_BINS) begin
                            r_bin   <= '0;
                            r_state <= S_BCLR;
                        end else if (r_cnt == '0) begin
                            r_state <= S_APP;
                        end else begin
                            r_state <= S_EVC;
                        end
                    end
                end
                // evict hits too old for the new one, or the oldest from a full store
                S_EVC: begin
                    if (ev_diff >= TIME_W'(r_wlen) || r_cnt == CW'(WINDOW_DEPTH)) begin
                        r_adc <= r_adc - ACC_W'(r_hit_rd.adc);
                        r_pk  <= r_pk - SUM16_W'(r_hit_rd.peak);
                        r_tot <= r_tot - SUM16_W'(r_hit_rd.tot);
                        r_ptr <= ptr_nx;
                        r_cnt <= r_cnt - CW'(1);
                        if (ev_diff >= TIME_W'(r_wlen)) begin
                            if (r_cnt == CW'(1)) r_state <= S_APP;
                        end else begin
                            r_ovf   <= 1'b1;
                            r_state <= S_FULL;
                        end
                    end else begin
                        r_start <= r_hit_rd.start_time;
                        r_state <= S_APP;
                    end
                end
                // new oldest hit after a forced eviction
                S_FULL: begin
                    r_start <= r_hit_rd.start_time;
                    r_state <= S_APP;
                end
                // append or restart
                S_APP: begin
                    if (r_cnt == '0) begin
                        r_ptr   <= '0;
                        r_start <= r_item.start_time;
                        r_adc   <= ACC_W'(r_item.adc);
                        r_pk    <= SUM16_W'(r_item.peak);
                        r_tot   <= SUM16_W'(r_item.tot);
                    end else begin
                        r_adc <= r_adc + ACC_W'(r_item.adc);
                        r_pk  <= r_pk + SUM16_W'(r_item.peak);
                        r_tot <= r_tot + SUM16_W'(r_item.tot);
                    end
                    r_cnt   <= r_cnt + CW'(1);
                    r_valid <= 1'b1;
                    r_obin  <= 1'b0;
                    r_oidx  <= '0;
                    r_oval  <= '0;
                    r_olast <= 1'b1;
                    r_state <= S_POUT;
                end
                S_POUT: begin
                    r_state <= S_IDLE;
                end
                // clear sweep over the histogram
                S_BCLR: begin
                    if (r_bin == HCW'(HD - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_BRD;
                    end else begin
                        r_bin <= r_bin + HCW'(1);
                    end
                end
                S_BRD: begin
                    if (r_idx == r_cnt) begin
                        r_bin   <= '0;
                        r_state <= S_BORD;
                    end else begin
                        r_state <= S_BCHK;
                    end
                end
                // range check and divider load
                S_BCHK: begin
                    if (bin_in) begin
                        r_trem  <= bin_dt[RW-1:0];
                        r_crem  <= RW'(bin_cd);
                        r_tq    <= '0;
                        r_cq    <= '0;
                        r_k     <= KW'(QW - 1);
                        r_hadc  <= r_hit_rd.adc;
                        r_state <= S_BDIV;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_BRD;
                    end
                end
                // restoring division, one quotient bit a cycle
                S_BDIV: begin
                    if (r_trem >= tsh) begin
                        r_trem     <= r_trem - tsh;
                        r_tq[r_k]  <= 1'b1;
                    end
                    if (r_crem >= csh) begin
                        r_crem     <= r_crem - csh;
                        r_cq[r_k]  <= 1'b1;
                    end
                    if (r_k == '0) r_state <= S_BHRD;
                    else r_k <= r_k - KW'(1);
                end
                S_BHRD: begin
                    r_hidx  <= idx_full[HW-1:0];
                    r_state <= S_BHWR;
                end
                S_BHWR: begin
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_BRD;
                end
                S_BORD: begin
                    r_state <= S_BOEM;
                end
                // emit one bin
                S_BOEM: begin
                    r_valid <= 1'b1;
                    r_obin  <= 1'b1;
                    r_oidx  <= r_bin[HW-1:0];
                    r_oval  <= r_hist_rd;
                    r_olast <= (r_bin == r_nbins - HCW'(1));
                    if (r_bin == r_nbins - HCW'(1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_bin   <= r_bin + HCW'(1);
                        r_state <= S_BORD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign o_valid        = r_valid;
    assign o_is_bin       = r_obin;
    assign o_bin_idx      = 6'(r_oidx);
    assign o_bin_value    = r_oval;
    assign o_last         = r_olast;
    assign o_window_begin = r_start;
    assign o_hit_count    = 7'(r_cnt);
    assign o_adc_total    = r_adc;
    assign o_peak_total   = r_pk;
    assign o_tot_total    = r_tot;
    assign o_overflow     = r_ovf;

endmodule

>>> src/stwh_checker.sv
// ----------------------------------------------------------------------------
// stwh_checker
// Port-level checks of the sliding time window histogrammer.
// ----------------------------------------------------------------------------
module stwh_checker
    import stwh_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic               o_is_bin,
    input logic               o_last,
    input logic [6:0]         o_hit_count,
    input logic               o_overflow
);

    // an accepted request keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk)
        (i_rst_n && start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // a push gives a single, final result
    a_push_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_bin) |-> o_last)
        else $error("push result without last");

    // after a push the window holds at least the new hit
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_bin) |-> (o_hit_count != 7'd0))
        else $error("empty window after push");

    // bin results never report overflow
    a_bin_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_bin) |-> !o_overflow)
        else $error("overflow on bin result");

    // no result while idle unless it is the final one
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !busy) |-> o_last)
        else $error("non-final result after block went idle");

endmodule

bind sliding_time_window_histogrammer stwh_checker u_stwh_checker (.*);

>>> sim/tb_sliding_time_window_histogrammer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_time_window_histogrammer
// Drives hit pushes and histogram requests through several register settings
// and checks every result strobe against a cycle-free model of the window.
// ----------------------------------------------------------------------------
module tb_sliding_time_window_histogrammer;
    import stwh_pkg::*;

    localparam int DEPTH    = DEF_WINDOW_DEPTH;
    localparam int MAX_TB   = DEF_MAX_TIME_BINS;
    localparam int MAX_CB   = DEF_MAX_CHAN_BINS;
    localparam int CYC_MAX  = 1000000;

    typedef struct {
        logic               is_bin;
        logic [5:0]         bin_idx;
        logic [ACC_W-1:0]   bin_value;
        logic               last;
        logic [TIME_W-1:0]  window_begin;
        logic [6:0]         hit_count;
        logic [ACC_W-1:0]   adc_total;
        logic [SUM16_W-1:0] peak_total;
        logic [SUM16_W-1:0] tot_total;
        logic               overflow;
    } t_window_result;

    // window model and queue of expected results
    class stwh_scoreboard;
        t_hit               hits [DEPTH];
        int unsigned        oldest;
        int unsigned        held;
        logic [TIME_W-1:0]  begin_time;
        logic [ACC_W-1:0]   adc_sum;
        logic [SUM16_W-1:0] peak_sum;
        logic [SUM16_W-1:0] tot_sum;
        logic [31:0]        win_len;
        logic [31:0]        tbin_w;
        logic [15:0]        cbin_w;
        logic [CHAN_W-1:0]  chan0;
        logic [3:0]         tbins;
        logic [3:0]         cbins;
        t_window_result     pending [$];
        int                 errors;

        function new();
            oldest = 0; held = 0; begin_time = '0;
            adc_sum = '0; peak_sum = '0; tot_sum = '0;
            win_len = 1000; tbin_w = 100; cbin_w = 1; chan0 = '0;
            tbins = 8; cbins = 8; errors = 0;
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH %s", what);
        endtask

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_WINDOW_LENGTH:  win_len = data;
                REG_TIME_BIN_WIDTH: tbin_w = data;
                REG_CHAN_BIN_WIDTH: cbin_w = data[15:0];
                REG_FIRST_CHAN:     chan0 = data[CHAN_W-1:0];
                REG_TIME_BINS_USED: tbins = data[3:0];
                REG_CHAN_BINS_USED: cbins = data[3:0];
                default: ;
            endcase
        endfunction

        function void drop_oldest();
            adc_sum  -= ACC_W'(hits[oldest].adc);
            peak_sum -= SUM16_W'(hits[oldest].peak);
            tot_sum  -= SUM16_W'(hits[oldest].tot);
            oldest = (oldest + 1) % DEPTH;
            held--;
        endfunction

        function t_window_result status();
            t_window_result r;
            r.is_bin = 0; r.bin_idx = 0; r.bin_value = 0; r.last = 1;
            r.window_begin = begin_time; r.hit_count = 7'(held);
            r.adc_total = adc_sum; r.peak_total = peak_sum; r.tot_total = tot_sum;
            r.overflow = 0;
            return r;
        endfunction

        function void note_request(logic func, t_hit h);
            t_window_result r;
            logic [ACC_W-1:0] histo [MAX_TB*MAX_CB];
            logic [TIME_W-1:0] dt, tb, cb;
            int unsigned nt, nc, p;
            logic ovf;
            if (func == FUNC_PUSH) begin
                ovf = 0;
                while (held > 0 && !((h.start_time - hits[oldest].start_time) < 64'(win_len)))
                    drop_oldest();
                if (held == 0) begin
                    oldest = 0;
                    begin_time = h.start_time;
                    adc_sum = ACC_W'(h.adc);
                    peak_sum = SUM16_W'(h.peak);
                    tot_sum = SUM16_W'(h.tot);
                end else begin
                    if (held >= DEPTH) begin
                        drop_oldest();
                        ovf = 1;
                    end
                    begin_time = hits[oldest].start_time;
                    adc_sum  += ACC_W'(h.adc);
                    peak_sum += SUM16_W'(h.peak);
                    tot_sum  += SUM16_W'(h.tot);
                end
                hits[(oldest + held) % DEPTH] = h;
                held++;
                r = status();
                r.overflow = ovf;
                pending.insert(pending.size(), r);
            end else begin
                nt = (tbins == 0) ? 1 : (tbins > MAX_TB) ? MAX_TB : tbins;
                nc = (cbins == 0) ? 1 : (cbins > MAX_CB) ? MAX_CB : cbins;
                foreach (histo[i]) histo[i] = '0;
                for (int i = 0; i < held; i++) begin
                    p = (oldest + i) % DEPTH;
                    if (tbin_w == 0 || cbin_w == 0) continue;
                    if (hits[p].channel < chan0) continue;
                    dt = hits[p].start_time - begin_time;
                    tb = dt / 64'(tbin_w);
                    cb = 64'(hits[p].channel - chan0) / 64'(cbin_w);
                    if (tb < nt && cb < nc)
                        histo[cb * nt + tb] += ACC_W'(hits[p].adc);
                end
                for (int i = 0; i < nt * nc; i++) begin
                    r = status();
                    r.is_bin = 1;
                    r.bin_idx = 6'(i);
                    r.bin_value = histo[i];
                    r.last = (i + 1 == nt * nc);
                    pending.insert(pending.size(), r);
                end
            end
        endfunction

        task compare(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(t_window_result got);
            t_window_result want;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            want = pending.pop_front();
            compare("is_bin", got.is_bin, want.is_bin);
            compare("bin_idx", got.bin_idx, want.bin_idx);
            compare("bin_value", got.bin_value, want.bin_value);
            compare("last", got.last, want.last);
            compare("window_begin", got.window_begin, want.window_begin);
            compare("hit_count", got.hit_count, want.hit_count);
            compare("adc_total", got.adc_total, want.adc_total);
            compare("peak_total", got.peak_total, want.peak_total);
            compare("tot_total", got.tot_total, want.tot_total);
            compare("overflow", got.overflow, want.overflow);
        endtask
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 start = 0;
    logic                 busy;
    logic                 i_func = FUNC_PUSH;
    logic [TIME_W-1:0]    i_hit_start_time = '0;
    logic [CHAN_W-1:0]    i_hit_channel = '0;
    logic [ADC_W-1:0]     i_hit_adc_integral = '0;
    logic [PEAK_W-1:0]    i_hit_adc_peak = '0;
    logic [TOT_W-1:0]     i_hit_time_over_thr = '0;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 o_valid;
    logic                 o_is_bin;
    logic [5:0]           o_bin_idx;
    logic [ACC_W-1:0]     o_bin_value;
    logic                 o_last;
    logic [TIME_W-1:0]    o_window_begin;
    logic [6:0]           o_hit_count;
    logic [ACC_W-1:0]     o_adc_total;
    logic [SUM16_W-1:0]   o_peak_total;
    logic [SUM16_W-1:0]   o_tot_total;
    logic                 o_overflow;
    t_window_result       res;

    stwh_scoreboard window_sb = new();
    int                   cycles = 0;
    int                   idle_pct = 29;
    logic [TIME_W-1:0]    now_ticks = '0;

    sliding_time_window_histogrammer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_hit_start_time(i_hit_start_time),
        .i_hit_channel(i_hit_channel), .i_hit_adc_integral(i_hit_adc_integral),
        .i_hit_adc_peak(i_hit_adc_peak), .i_hit_time_over_thr(i_hit_time_over_thr),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_is_bin(o_is_bin), .o_bin_idx(o_bin_idx),
        .o_bin_value(o_bin_value), .o_last(o_last),
        .o_window_begin(o_window_begin), .o_hit_count(o_hit_count),
        .o_adc_total(o_adc_total), .o_peak_total(o_peak_total),
        .o_tot_total(o_tot_total), .o_overflow(o_overflow)
    );

    always #1 i_clk = ~i_clk;

    // result monitor and run limit
    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_valid) begin
            res.is_bin       = o_is_bin;
            res.bin_idx      = o_bin_idx;
            res.bin_value    = o_bin_value;
            res.last         = o_last;
            res.window_begin = o_window_begin;
            res.hit_count    = o_hit_count;
            res.adc_total    = o_adc_total;
            res.peak_total   = o_peak_total;
            res.tot_total    = o_tot_total;
            res.overflow     = o_overflow;
            window_sb.check_result(res);
        end
        if (cycles > CYC_MAX) begin
            $display("sliding_time_window_histogrammer verification failed");
            $finish;
        end
    end

    // one request, with a random gap first
    task automatic send_request(logic func, t_hit h);
        while ($urandom_range(99) < idle_pct)
            @(negedge i_clk);
        start = 1;
        i_func = func;
        i_hit_start_time = h.start_time;
        i_hit_channel = h.channel;
        i_hit_adc_integral = h.adc;
        i_hit_adc_peak = h.peak;
        i_hit_time_over_thr = h.tot;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        window_sb.note_request(func, h);
        @(negedge i_clk);
        start = 0;
    endtask

    task automatic push_hit(logic [TIME_W-1:0] t, logic [CHAN_W-1:0] ch,
                            logic [ADC_W-1:0] adc, logic [PEAK_W-1:0] pk,
                            logic [TOT_W-1:0] tt);
        t_hit h;
        h.start_time = t; h.channel = ch; h.adc = adc; h.peak = pk; h.tot = tt;
        now_ticks = t;
        send_request(FUNC_PUSH, h);
    endtask

    task automatic request_bins();
        t_hit h;
        h.start_time = {$urandom, $urandom}; h.channel = CHAN_W'($urandom);
        h.adc = $urandom; h.peak = PEAK_W'($urandom); h.tot = TOT_W'($urandom);
        send_request(FUNC_BINS, h);
    endtask

    // waits until every expected result is in and the block is idle
    task automatic drain();
        while (window_sb.pending.size() != 0 || busy)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        window_sb.note_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic set_regs(logic [31:0] wl, logic [31:0] tbw, logic [31:0] cbw,
                            logic [31:0] fc, logic [31:0] nt, logic [31:0] nc);
        drain();
        write_reg(REG_WINDOW_LENGTH, wl);
        write_reg(REG_TIME_BIN_WIDTH, tbw);
        write_reg(REG_CHAN_BIN_WIDTH, cbw);
        write_reg(REG_FIRST_CHAN, fc);
        write_reg(REG_TIME_BINS_USED, nt);
        write_reg(REG_CHAN_BINS_USED, nc);
    endtask

    // random hit near the current time, sometimes a jump or a step back
    task automatic random_push(int max_step, int max_chan);
        logic [TIME_W-1:0] t;
        int sel;
        sel = $urandom_range(99);
        if (sel < 4)
            t = {$urandom, $urandom};
        else if (sel < 8)
            t = now_ticks - $urandom_range(500);
        else
            t = now_ticks + $urandom_range(max_step);
        push_hit(t, (sel % 10 == 9) ? CHAN_W'($urandom) : CHAN_W'($urandom_range(max_chan)),
                 $urandom, PEAK_W'($urandom), TOT_W'($urandom));
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: defaults, field extremes, empty window, going backwards
        request_bins();
        push_hit('0, '0, '0, '0, '0);
        push_hit(64'd150, CHAN_W'(7), '1, '1, '1);
        push_hit(64'd420, CHAN_W'(3), 32'd1000, 16'd5, 16'd9);
        push_hit(64'd999, '1, 32'd77, 16'd1, 16'd2);
        request_bins();
        push_hit(64'd1400, CHAN_W'(2), 32'd12, 16'd3, 16'd4);
        push_hit(64'd100, CHAN_W'(1), 32'd5, 16'd6, 16'd7);
        push_hit('1, CHAN_W'(4), '1, '1, '1);
        push_hit('1, CHAN_W'(5), '1, '1, '1);
        request_bins();

        // zero widths and lengths, bin counts below and above range
        set_regs(32'd0, 32'd0, 32'd0, 32'd5, 32'd0, 32'd15);
        push_hit(64'd10, CHAN_W'(6), 32'd3, 16'd4, 16'd5);
        push_hit(64'd10, CHAN_W'(8), 32'd3, 16'd4, 16'd5);
        request_bins();
        set_regs(32'd500, 32'd50, 32'd2, 32'd5, 32'd15, 32'd0);
        push_hit(64'd20, CHAN_W'(2), 32'd9, 16'd1, 16'd1);
        push_hit(64'd60, CHAN_W'(9), 32'd8, 16'd1, 16'd1);
        push_hit(64'd330, CHAN_W'(5), 32'd7, 16'd1, 16'd1);
        request_bins();

        // widest settings and a full store with overflow
        set_regs('1, '1, 32'hFFFF, 32'hFFFFF, 32'd8, 32'd8);
        for (int i = 0; i < 70; i++) begin
            push_hit(now_ticks + 64'(i), CHAN_W'(i), $urandom, PEAK_W'($urandom),
                     TOT_W'($urandom));
            if (i == 66) request_bins();
        end
        request_bins();
        set_regs(32'd100000, 32'd1, 32'd1, 32'd0, 32'd1, 32'd1);
        request_bins();

        // random traffic over several settings and idle levels
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 29 : (ph == 1) ? 58 : 0;
            for (int k = 0; k < 2; k++) begin
                set_regs($urandom_range(5000, 200), $urandom_range(700, 20),
                         $urandom_range(4, 1), $urandom_range(10),
                         $urandom_range(8, 1), $urandom_range(8, 1));
                for (int i = 0; i < 6; i++) begin
                    if ($urandom_range(99) < 15) request_bins();
                    else random_push(300, 40);
                end
                request_bins();
            end
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (window_sb.errors == 0 && window_sb.pending.size() == 0) begin
            $display("sliding_time_window_histogrammer verification clean");
        end else begin
            $display("sliding_time_window_histogrammer verification failed");
        end
        $finish;
    end

endmodule
